/* design/pesh_pkg.sv */
// Shared types, constants and byte builders for the PES header builder.
`timescale 1ns / 1ps
`default_nettype none

package pesh_pkg;

   // Field widths
   localparam int unsigned TS_W      = 33;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned BITRATE_W = 31;
   localparam int unsigned RATE_W    = 22;
   localparam int unsigned IDX_W     = 5;
   localparam int unsigned CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_BITRATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_BITRATE = 2'd1;

   // bitrate/400 == (bitrate >> 4) / 25; /25 by reciprocal 2^32/25, rounded up
   localparam int unsigned RATE_SHIFT = 4;
   localparam int unsigned RECIP_W    = 28;
   localparam int unsigned RECIP_Q    = 32;
   localparam logic [RECIP_W-1:0] RECIP_25 = 28'd171798692;

   // Header byte values
   localparam logic [7:0] START_BYTE0  = 8'h00;
   localparam logic [7:0] START_BYTE2  = 8'h01;
   localparam logic [7:0] ID_VIDEO     = 8'hE0;
   localparam logic [7:0] ID_AUDIO     = 8'hC0;
   localparam logic [7:0] MARKER_BYTE  = 8'h84;
   localparam logic [7:0] FLAGS_NONE   = 8'h10;
   localparam logic [7:0] FLAGS_PTS    = 8'h90;
   localparam logic [7:0] FLAGS_BOTH   = 8'hD0;
   localparam logic [7:0] HLEN_NONE    = 8'd3;
   localparam logic [7:0] HLEN_PTS     = 8'd8;
   localparam logic [7:0] HLEN_BOTH    = 8'd13;
   localparam logic [3:0] PREFIX_PTS   = 4'h2;
   localparam logic [3:0] PREFIX_BOTH  = 4'h3;
   localparam logic [3:0] PREFIX_DTS   = 4'h1;

   // Packet length addends (header bytes minus 6)
   localparam logic [LEN_W-1:0] LEN_ADD_NONE = 16'd6;
   localparam logic [LEN_W-1:0] LEN_ADD_PTS  = 16'd11;
   localparam logic [LEN_W-1:0] LEN_ADD_BOTH = 16'd16;

   // Byte positions
   localparam logic [IDX_W-1:0] IDX_START0  = 5'd0;
   localparam logic [IDX_W-1:0] IDX_START1  = 5'd1;
   localparam logic [IDX_W-1:0] IDX_START2  = 5'd2;
   localparam logic [IDX_W-1:0] IDX_ID      = 5'd3;
   localparam logic [IDX_W-1:0] IDX_LEN_HI  = 5'd4;
   localparam logic [IDX_W-1:0] IDX_LEN_LO  = 5'd5;
   localparam logic [IDX_W-1:0] IDX_MARKER  = 5'd6;
   localparam logic [IDX_W-1:0] IDX_FLAGS   = 5'd7;
   localparam logic [IDX_W-1:0] IDX_HLEN    = 5'd8;
   localparam logic [IDX_W-1:0] IDX_STAMP0  = 5'd9;
   localparam logic [IDX_W-1:0] IDX_STAMP1  = 5'd14;
   localparam logic [IDX_W-1:0] STAMP_BYTES = 5'd5;
   localparam logic [IDX_W-1:0] LAST_NONE   = 5'd11;
   localparam logic [IDX_W-1:0] LAST_PTS    = 5'd16;
   localparam logic [IDX_W-1:0] LAST_BOTH   = 5'd21;

   // Which time stamps a packet carries
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PTS  = 2'd1,
      KIND_BOTH = 2'd2
   } kind_type;

   // One classified request, as held in the queue
   typedef struct packed {
      logic              mode;
      kind_type          kind;
      logic [TS_W-1:0]   pts;
      logic [TS_W-1:0]   dts;
      logic [LEN_W-1:0]  pkt_len;
      logic [RATE_W-1:0] rate;
   } entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Byte k of a 5-byte time stamp field with markers
   function automatic logic [7:0] stamp_byte(input logic [3:0] prefix,
                                             input logic [TS_W-1:0] ts,
                                             input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = {prefix, ts[32:30], 1'b1};
         3'd1:    b = ts[29:22];
         3'd2:    b = {ts[21:15], 1'b1};
         3'd3:    b = ts[14:7];
         default: b = {ts[6:0], 1'b1};
      endcase
      return b;
   endfunction

   // Byte k of the 3-byte ES rate field
   function automatic logic [7:0] rate_byte(input logic [RATE_W-1:0] rate,
                                            input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = {1'b1, rate[21:15]};
         2'd1:    b = rate[14:7];
         default: b = {rate[6:0], 1'b1};
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

/* design/pesh_queue.sv */
// Short FIFO of classified requests between the front and back sides.
`timescale 1ns / 1ps
`default_nettype none

module pesh_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  pesh_pkg::entry_type    push_entry,
   input  wire                    pop,
   output pesh_pkg::entry_type    head_entry,
   output pesh_pkg::q_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pesh_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head_entry   = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

endmodule

`default_nettype wire

/* design/pesh_front.sv */
// Request intake: bitrate registers, classification, length and ES rate.
`timescale 1ns / 1ps
`default_nettype none

module pesh_front (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_mode,
   input  wire  [pesh_pkg::TS_W-1:0]            req_pts,
   input  wire  [pesh_pkg::TS_W-1:0]            req_dts,
   input  wire  [pesh_pkg::LEN_W-1:0]           req_payload_length,
   // configuration channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [pesh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [pesh_pkg::BITRATE_W-1:0]       csr_wdata,
   // queue side
   output logic                                 q_push,
   output pesh_pkg::entry_type                  q_entry,
   input  pesh_pkg::q_status_type               q_status
);

   localparam int unsigned DIV_IN_W = pesh_pkg::BITRATE_W - pesh_pkg::RATE_SHIFT;
   localparam int unsigned PROD_W   = DIV_IN_W + pesh_pkg::RECIP_W;

   logic [pesh_pkg::BITRATE_W-1:0] video_bitrate_ff;
   logic [pesh_pkg::BITRATE_W-1:0] audio_bitrate_ff;
   logic                           stage_valid_ff, stage_valid_in;
   pesh_pkg::entry_type            stage_ff, stage_in;
   logic                           req_accept;
   logic [pesh_pkg::BITRATE_W-1:0] bitrate_sel;
   logic [DIV_IN_W-1:0]            div_in;
   logic [PROD_W-1:0]              prod;

   assign csr_ready  = 1'b1;
   assign req_stall  = stage_valid_ff && q_status.full;
   assign req_accept = req_valid && !req_stall;
   assign q_push     = stage_valid_ff && !q_status.full;
   assign q_entry    = stage_ff;

   // Bitrate registers
   always_ff @(posedge clock) begin
      if (reset) begin
         video_bitrate_ff <= '0;
         audio_bitrate_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pesh_pkg::CSR_VIDEO_BITRATE: video_bitrate_ff <= csr_wdata;
            pesh_pkg::CSR_AUDIO_BITRATE: audio_bitrate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ES rate: bitrate/400 as (bitrate>>4) * ceil(2^32/25) >> 32
   assign bitrate_sel = req_mode ? audio_bitrate_ff : video_bitrate_ff;
   assign div_in      = bitrate_sel[pesh_pkg::BITRATE_W-1:pesh_pkg::RATE_SHIFT];
   assign prod        = PROD_W'(div_in) * PROD_W'(pesh_pkg::RECIP_25);

   // Classify and build the queue word
   always_comb begin
      stage_in      = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (q_push) begin
         stage_valid_in = 1'b0;
      end
      if (req_accept) begin
         stage_valid_in = 1'b1;
         stage_in.mode  = req_mode;
         stage_in.pts   = req_pts;
         stage_in.dts   = req_dts;
         stage_in.rate  = prod[pesh_pkg::RECIP_Q +: pesh_pkg::RATE_W];
         if (req_pts != '0 && req_dts != '0) begin
            stage_in.kind    = pesh_pkg::KIND_BOTH;
            stage_in.pkt_len = req_payload_length + pesh_pkg::LEN_ADD_BOTH;
         end else if (req_pts != '0) begin
            stage_in.kind    = pesh_pkg::KIND_PTS;
            stage_in.pkt_len = req_payload_length + pesh_pkg::LEN_ADD_PTS;
         end else begin
            stage_in.kind    = pesh_pkg::KIND_NONE;
            stage_in.pkt_len = req_payload_length + pesh_pkg::LEN_ADD_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && q_status.full) |=> stage_valid_ff)
      else $error("front word dropped while queue full");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("front pushed into a full queue");

   a_stalled_word_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(stage_ff))
      else $error("front word changed while stalled");

endmodule

`default_nettype wire

/* design/pesh_back.sv */
// Byte sequencer: walks the head queue word and emits header bytes.
`timescale 1ns / 1ps
`default_nettype none

module pesh_back (
   input  wire                         clock,
   input  wire                         reset,
   // queue side
   input  pesh_pkg::entry_type         q_entry,
   input  pesh_pkg::q_status_type      q_status,
   output logic                        q_pop,
   // response channel
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [7:0]                  rsp_header_byte,
   output logic                        rsp_last
);

   logic [pesh_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff, rsp_byte_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       advance;
   logic                       load;
   logic [pesh_pkg::IDX_W-1:0] last_idx;
   logic [pesh_pkg::IDX_W-1:0] ts_end;
   logic [pesh_pkg::IDX_W-1:0] stamp_off;
   logic [pesh_pkg::IDX_W-1:0] rate_off;
   logic [7:0]                 flags;
   logic [7:0]                 hlen;
   logic [3:0]                 first_prefix;
   logic                       is_last;
   logic [7:0]                 cur_byte;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_header_byte = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = advance && !q_status.empty;
   assign is_last = (idx_ff == last_idx);
   assign q_pop   = load && is_last;

   // Per-kind layout
   always_comb begin
      case (q_entry.kind)
         pesh_pkg::KIND_BOTH: begin
            last_idx     = pesh_pkg::LAST_BOTH;
            ts_end       = pesh_pkg::IDX_STAMP1 + pesh_pkg::STAMP_BYTES;
            flags        = pesh_pkg::FLAGS_BOTH;
            hlen         = pesh_pkg::HLEN_BOTH;
            first_prefix = pesh_pkg::PREFIX_BOTH;
         end
         pesh_pkg::KIND_PTS: begin
            last_idx     = pesh_pkg::LAST_PTS;
            ts_end       = pesh_pkg::IDX_STAMP1;
            flags        = pesh_pkg::FLAGS_PTS;
            hlen         = pesh_pkg::HLEN_PTS;
            first_prefix = pesh_pkg::PREFIX_PTS;
         end
         default: begin
            last_idx     = pesh_pkg::LAST_NONE;
            ts_end       = pesh_pkg::IDX_STAMP0;
            flags        = pesh_pkg::FLAGS_NONE;
            hlen         = pesh_pkg::HLEN_NONE;
            first_prefix = pesh_pkg::PREFIX_PTS;
         end
      endcase
   end

   // Byte select by position
   always_comb begin
      stamp_off = idx_ff - ((idx_ff < pesh_pkg::IDX_STAMP1) ? pesh_pkg::IDX_STAMP0
                                                            : pesh_pkg::IDX_STAMP1);
      rate_off  = idx_ff - ts_end;
      if (idx_ff < pesh_pkg::IDX_STAMP0) begin
         case (idx_ff)
            pesh_pkg::IDX_START0: cur_byte = pesh_pkg::START_BYTE0;
            pesh_pkg::IDX_START1: cur_byte = pesh_pkg::START_BYTE0;
            pesh_pkg::IDX_START2: cur_byte = pesh_pkg::START_BYTE2;
            pesh_pkg::IDX_ID:
               cur_byte = q_entry.mode ? pesh_pkg::ID_AUDIO : pesh_pkg::ID_VIDEO;
            pesh_pkg::IDX_LEN_HI: cur_byte = q_entry.pkt_len[15:8];
            pesh_pkg::IDX_LEN_LO: cur_byte = q_entry.pkt_len[7:0];
            pesh_pkg::IDX_MARKER: cur_byte = pesh_pkg::MARKER_BYTE;
            pesh_pkg::IDX_FLAGS:  cur_byte = flags;
            default:              cur_byte = hlen;
         endcase
      end else if (idx_ff < ts_end) begin
         if (idx_ff < pesh_pkg::IDX_STAMP1) begin
            cur_byte = pesh_pkg::stamp_byte(first_prefix, q_entry.pts, stamp_off[2:0]);
         end else begin
            cur_byte = pesh_pkg::stamp_byte(pesh_pkg::PREFIX_DTS, q_entry.dts,
                                            stamp_off[2:0]);
         end
      end else begin
         cur_byte = pesh_pkg::rate_byte(q_entry.rate, rate_off[1:0]);
      end
   end

   // Output register and position counter
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = !q_status.empty;
      end
      if (load) begin
         rsp_byte_in = cur_byte;
         rsp_last_in = is_last;
         idx_in      = is_last ? '0 : idx_ff + pesh_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_idx_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (idx_ff == '0))
      else $error("byte position not cleared after last byte");

   a_idx_stalled: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty || !advance) |=> $stable(idx_ff))
      else $error("byte position moved without a byte");

   a_last_matches_pop: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_last_ff == $past(q_pop)))
      else $error("last flag and queue pop disagree");

endmodule

`default_nettype wire

/* design/pes_header_builder.sv */
// Top level of the PES header builder: front, queue and byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted request produces one PES header, one byte per cycle while
// rsp_stall is low, on the rsp_ channel with rsp_last on its final byte: 22
// bytes when PTS and DTS are both nonzero, 17 with PTS only and 12 without a
// PTS. The byte sequencer is the limit; it moves straight from one header to
// the next without a gap when the next request is already queued. A request
// passes through the front register and a queue slot, and each of its bytes
// through the output register, on the way to the rsp_ port. The front side
// registers a request, works out the packet length and the ES rate
// (bitrate / 400 by a reciprocal multiply) and parks it in a
// QUEUE_DEPTH-entry queue, so further requests are taken while a header is
// still going out. Bitrate registers are written through csr_ (index 0
// video, 1 audio); csr_ready is always high.
module pes_header_builder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_mode,
   input  wire  [pesh_pkg::TS_W-1:0]         req_pts,
   input  wire  [pesh_pkg::TS_W-1:0]         req_dts,
   input  wire  [pesh_pkg::LEN_W-1:0]        req_payload_length,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [7:0]                        rsp_header_byte,
   output logic                              rsp_last,
   // configuration channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [pesh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [pesh_pkg::BITRATE_W-1:0]    csr_wdata
);

   logic                   q_push;
   logic                   q_pop;
   pesh_pkg::entry_type    q_push_entry;
   pesh_pkg::entry_type    q_head_entry;
   pesh_pkg::q_status_type q_status;

   pesh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_pts            (req_pts),
      .req_dts            (req_dts),
      .req_payload_length (req_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_push             (q_push),
      .q_entry            (q_push_entry),
      .q_status           (q_status)
   );

   pesh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .status     (q_status)
   );

   pesh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_entry         (q_head_entry),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_byte (rsp_header_byte),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
